@@ sv/q16_pkg.sv @@
`default_nettype none
package q16_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1,
        OP_ABS = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    // classified request handed from front to back
    typedef struct packed {
        op_t                op;
        logic               neg;
        logic               dz;
        logic               ovf;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic        [31:0] rem;
        logic        [31:0] nlow;
        logic        [31:0] d;
        logic        [31:0] q;
    } req_t;

endpackage
`default_nettype wire

@@ sv/q16_front.sv @@
`default_nettype none
module q16_front #(
    parameter int FRAC_BITS = q16_pkg::FRAC_BITS_DEF
) (
    input  wire logic        [1:0]  op,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output q16_pkg::req_t           req
);

    localparam int SH = 32 - FRAC_BITS;

    logic [31:0] amag;
    logic [31:0] bmag;

    always_comb
    begin
        amag = a[31] ? (32'd0 - a) : a;
        bmag = b[31] ? (32'd0 - b) : b;
        req = '0;
        req.op = q16_pkg::op_t'(op);
        req.a = a;
        req.b = b;
        req.neg = a[31] ^ b[31];
        req.d = bmag;
        req.rem = amag >> SH;
        req.nlow = amag << FRAC_BITS;
        case (q16_pkg::op_t'(op))
            q16_pkg::OP_DIV:
            begin
                req.dz = (b == 32'sd0);
                req.ovf = (b != 32'sd0) && ((amag >> SH) >= bmag);
            end
            q16_pkg::OP_ABS:
            begin
                req.q = amag;
            end
            default:
            begin
                req.q = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/q16_queue.sv @@
`default_nettype none
module q16_queue #(
    parameter int DEPTH = q16_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  q16_pkg::req_t      wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output q16_pkg::req_t      rd_data,
    output logic               rd_vld
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q16_pkg::req_t  mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_wr, do_rd;

    assign full = (cnt_reg == CW'(DEPTH));
    assign rd_vld = (cnt_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && rd_vld;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH)) else $error("queue count overflow");

endmodule
`default_nettype wire

@@ sv/q16_back.sv @@
`default_nettype none
module q16_back #(
    parameter int FRAC_BITS = q16_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  q16_pkg::req_t           in_req,
    input  wire logic               in_vld,
    output logic                    in_take,
    output logic signed [31:0]      result,
    output logic                    saturated,
    output logic                    div_by_zero,
    output logic                    empty,
    input  wire logic               pop
);

    localparam int NST = 33;
    localparam logic signed [63:0] PLO = -(64'sd1 <<< (31 + FRAC_BITS));
    localparam logic signed [63:0] PHI = ((64'sd1 <<< 31) - 64'sd1) <<< FRAC_BITS;

    q16_pkg::req_t       st_reg [NST];
    q16_pkg::req_t       mul_next;
    logic [NST-1:0]      vld_reg;
    logic signed [63:0]  prod_reg;
    logic                en;
    logic signed [31:0]  res_reg, res_next;
    logic                sat_reg, sat_next;
    logic                dz_reg;
    logic                out_vld_reg;

    function automatic q16_pkg::req_t div_step(input q16_pkg::req_t s);
        q16_pkg::req_t r;
        logic [32:0]   t;
        r = s;
        t = {s.rem, s.nlow[31]};
        if (s.op == q16_pkg::OP_DIV)
        begin
            r.nlow = {s.nlow[30:0], 1'b0};
            if (t >= {1'b0, s.d})
            begin
                r.rem = 32'(t - {1'b0, s.d});
                r.q = {s.q[30:0], 1'b1};
            end
            else
            begin
                r.rem = t[31:0];
                r.q = {s.q[30:0], 1'b0};
            end
        end
        return r;
    endfunction

    assign en = !out_vld_reg || pop;
    assign in_take = en && in_vld;
    assign empty = !out_vld_reg;
    assign result = res_reg;
    assign saturated = sat_reg;
    assign div_by_zero = dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_vld};
            out_vld_reg <= vld_reg[NST-1];
        end
    end

    always_comb
    begin
        mul_next = st_reg[0];
        if (prod_reg < PLO)
        begin
            mul_next.q = 32'h8000_0000;
            mul_next.ovf = 1'b1;
        end
        else if (prod_reg > PHI)
        begin
            mul_next.q = 32'h7FFF_FFFF;
            mul_next.ovf = 1'b1;
        end
        else
        begin
            mul_next.q = 32'(prod_reg >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= in_req;
            prod_reg <= 64'(in_req.a) * 64'(in_req.b);
            if (st_reg[0].op == q16_pkg::OP_MUL)
            begin
                st_reg[1] <= mul_next;
            end
            else
            begin
                st_reg[1] <= div_step(st_reg[0]);
            end
            for (int k = 2; k < NST; k++)
            begin
                st_reg[k] <= div_step(st_reg[k-1]);
            end
        end
    end

    always_comb
    begin
        q16_pkg::req_t s;
        s = st_reg[NST-1];
        res_next = $signed(s.q);
        sat_next = 1'b0;
        case (s.op)
            q16_pkg::OP_MUL:
            begin
                sat_next = s.ovf;
            end
            q16_pkg::OP_DIV:
            begin
                if (s.dz)
                begin
                    res_next = 32'sd0;
                end
                else if (s.neg)
                begin
                    if (s.ovf || s.q > 32'h8000_0000)
                    begin
                        res_next = 32'sh8000_0000;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        res_next = $signed(32'd0 - s.q);
                    end
                end
                else if (s.ovf || s.q > 32'h7FFF_FFFF)
                begin
                    res_next = 32'sh7FFF_FFFF;
                    sat_next = 1'b1;
                end
            end
            default:
            begin
                res_next = $signed(s.q);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
            dz_reg <= st_reg[NST-1].dz && (st_reg[NST-1].op == q16_pkg::OP_DIV);
        end
    end

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && dz_reg) |-> (res_reg == 32'sd0 && !sat_reg))
        else $error("zero divisor result not clean");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !pop) |=> (out_vld_reg && $stable(res_reg)))
        else $error("request dropped while stalled");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline advanced during stall");

endmodule
`default_nettype wire

@@ sv/q16_16_mul_div_unit.sv @@
`default_nettype none
// Q16.16 signed multiply / divide / abs unit.
// Input queue side: drive op, a, b and raise push; a request is taken at a
// clock edge where push is high and full is low. op 0 multiplies, 1 divides,
// 2 takes the absolute value of a, 3 gives zero.
// Result queue side: while empty is low, result, saturated and div_by_zero
// show the oldest request; raise pop to take it.
// A front stage classifies each request (magnitudes, sign, zero divisor,
// quotient overflow) and places it in a short queue. The back pipeline has
// one multiply stage followed by 32 one-bit restoring divide stages and an
// output register, and one request per cycle is sustained while pop is high.
// While a result waits and pop is low the back pipeline holds; the queue keeps
// taking requests until it fills, then full rises.
// Reset clears the queue and all valid bits; nothing is pending after it.
module q16_16_mul_div_unit #(
    parameter int FRAC_BITS   = q16_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = q16_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic        [1:0]  op,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      result,
    output logic                    saturated,
    output logic                    div_by_zero
);

    q16_pkg::req_t front_req;
    q16_pkg::req_t queue_req;
    logic          queue_vld;
    logic          back_take;

    q16_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .op  (op),
        .a   (a),
        .b   (b),
        .req (front_req)
    );

    q16_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_req),
        .full    (full),
        .rd_en   (back_take),
        .rd_data (queue_req),
        .rd_vld  (queue_vld)
    );

    q16_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_req      (queue_req),
        .in_vld      (queue_vld),
        .in_take     (back_take),
        .result      (result),
        .saturated   (saturated),
        .div_by_zero (div_by_zero),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
`default_nettype wire
